FILE: hw/rtl/cta_pkg.sv
// Shared types, constants and arithmetic helpers of the coverage compositor.
package cta_pkg;

	localparam logic [7:0]  CHAN_MAX   = 8'd255;
	localparam logic [16:0] CHAN_SQ    = 17'd65025;
	localparam logic [8:0]  RECIP_SQ   = 9'd258;
	localparam int          NUM_CHAN   = 3;

	localparam logic [1:0] CFG_FILL_COLOR   = 2'd0;
	localparam logic [1:0] CFG_EDGE_COLOR   = 2'd1;
	localparam logic [1:0] CFG_PREMULT_MODE = 2'd2;

	typedef struct packed {
		logic                      valid;
		logic [7:0]                alpha;
		logic [NUM_CHAN-1:0][8:0]  color;
	} blend_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] alpha;
		logic [7:0] level;
	} lane_t;

	typedef struct packed {
		logic [1:0] q;
		logic [7:0] rem;
	} div2_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	// two restoring division steps; rem stays below d
	function automatic div2_t div_step2(input logic [7:0] rem, input logic [1:0] bits,
			input logic [7:0] d);
		div2_t      res;
		logic [8:0] t;
		logic [7:0] r;
		r = rem;
		for (int i = 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, d}) begin
				res.q[i] = 1'b1;
				r = 8'(t - {1'b0, d});
			end else begin
				res.q[i] = 1'b0;
				r = t[7:0];
			end
		end
		res.rem = r;
		return res;
	endfunction

endpackage

FILE: hw/rtl/coverage_to_argb_compositor.sv
// Top level of the coverage-to-ARGB compositor: registers, pipeline and output.
//
// Each input word carries the body and fill coverage of one pixel; each output
// word is the composited 32-bit ARGB pixel, alpha in the top byte, blue lowest.
// Both channels use valid/ready. The configuration port writes fill colour,
// edge colour and the premultiplied flag with cfg_we, cfg_idx and cfg_data;
// write it only while no pixel is in flight.
// From input acceptance to output valid a pixel passes four blend stages
// (coverage products, second product, reciprocal estimate, correction and
// sum) and five lane stages (saturation setup plus four stages of the
// straight-alpha divider, two quotient bits each).
// Throughput is one pixel per cycle; every multiplier and divider stage is
// fully pipelined, so a new pixel enters on each cycle the output is free.
// Reset empties the pipeline and loads fill colour 0xFFFFFF, edge colour 0
// and premultiplied mode.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module coverage_to_argb_compositor
	import cta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  body_coverage,
	input  logic [7:0]  fill_coverage,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] argb_pixel
);

	logic [23:0] fill_color_q;
	logic [23:0] edge_color_q;
	logic        premult_q;

	logic   adv;
	blend_t blend;
	lane_t  lane [NUM_CHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= 24'hFFFFFF;
			edge_color_q <= 24'h000000;
			premult_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FILL_COLOR:   fill_color_q <= cfg_data;
				CFG_EDGE_COLOR:   edge_color_q <= cfg_data;
				CFG_PREMULT_MODE: premult_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance unless a finished word is held by the receiver
	assign adv      = ~lane[0].valid | out_ready;
	assign in_ready = adv;

	cta_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.body       (body_coverage),
		.fill       (fill_coverage),
		.fill_color (fill_color_q),
		.edge_color (edge_color_q),
		.res        (blend)
	);

	for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
		cta_div_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (blend.valid),
			.alpha    (blend.alpha),
			.color    (blend.color[k]),
			.premult  (premult_q),
			.res      (lane[k])
		);
	end

	assign out_valid  = lane[0].valid;
	assign argb_pixel = (lane[0].alpha == 8'd0) ? 32'd0 :
		{lane[0].alpha, lane[2].level, lane[1].level, lane[0].level};

endmodule

FILE: hw/rtl/cta_blend.sv
// Four-stage blend of the two coverage layers into alpha and premultiplied colour.
module cta_blend
	import cta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [7:0]  body,
	input  logic [7:0]  fill,
	input  logic [23:0] fill_color,
	input  logic [23:0] edge_color,
	output blend_t      res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [15:0]               prod_s1;
	logic [7:0]                nf_s1;
	logic [NUM_CHAN-1:0][15:0] eb_s1;
	logic [NUM_CHAN-1:0][15:0] ff_s1;

	logic [7:0]                alpha_s2;
	logic [NUM_CHAN-1:0][23:0] y_s2;
	logic [NUM_CHAN-1:0][7:0]  fterm_s2;

	logic [7:0]                alpha_s3;
	logic [NUM_CHAN-1:0][23:0] y_s3;
	logic [NUM_CHAN-1:0][7:0]  fterm_s3;
	logic [NUM_CHAN-1:0][7:0]  q0_s3;

	logic [7:0]                alpha_s4;
	logic [NUM_CHAN-1:0][8:0]  color_s4;

	logic [7:0]                nb, nf;
	logic [NUM_CHAN-1:0][32:0] est;
	logic [NUM_CHAN-1:0][24:0] back;
	logic [NUM_CHAN-1:0][16:0] rest;
	logic [NUM_CHAN-1:0][7:0]  eterm;

	assign nb = CHAN_MAX - body;
	assign nf = CHAN_MAX - fill;

	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			est[k]   = 33'(y_s2[k]) * 33'(RECIP_SQ);
			back[k]  = 25'(q0_s3[k]) * 25'(CHAN_SQ);
			rest[k]  = 17'(25'(y_s3[k]) - back[k]);
			eterm[k] = q0_s3[k] + ((rest[k] >= CHAN_SQ) ? 8'd1 : 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= 16'(nb) * 16'(nf);
			nf_s1    <= nf;
			alpha_s2 <= CHAN_MAX - div255(prod_s1);
			alpha_s3 <= alpha_s2;
			alpha_s4 <= alpha_s3;
			for (int k = 0; k < NUM_CHAN; k++) begin
				eb_s1[k]    <= 16'(edge_color[8*k +: 8]) * 16'(body);
				ff_s1[k]    <= 16'(fill_color[8*k +: 8]) * 16'(fill);
				y_s2[k]     <= 24'(eb_s1[k]) * 24'(nf_s1);
				fterm_s2[k] <= div255(ff_s1[k]);
				q0_s3[k]    <= est[k][31:24];
				y_s3[k]     <= y_s2[k];
				fterm_s3[k] <= fterm_s2[k];
				color_s4[k] <= 9'(eterm[k]) + 9'(fterm_s3[k]);
			end
		end
	end

	assign res.valid = valid_s4;
	assign res.alpha = alpha_s4;
	assign res.color = color_s4;

endmodule

FILE: hw/rtl/cta_div_lane.sv
// One colour lane: pass the premultiplied level through, or saturate or divide by alpha, two quotient bits per stage.
module cta_div_lane
	import cta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_valid,
	input  logic [7:0] alpha,
	input  logic [8:0] color,
	input  logic       premult,
	output lane_t      res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [7:0] d_s1, d_s2, d_s3, d_s4, d_s5;
	logic       sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;
	logic [7:0] pm_s1, pm_s2, pm_s3, pm_s4, pm_s5;
	logic [7:0] rem_s1, rem_s2, rem_s3, rem_s4;
	logic [7:0] low_s1, low_s2, low_s3, low_s4;
	logic [7:0] q_s2, q_s3, q_s4, q_s5;

	logic [15:0] num;
	div2_t       st2, st3, st4, st5;

	assign num = {color[7:0], 8'd0} - 16'(color[7:0]);
	assign st2 = div_step2(rem_s1, low_s1[7:6], d_s1);
	assign st3 = div_step2(rem_s2, low_s2[7:6], d_s2);
	assign st4 = div_step2(rem_s3, low_s3[7:6], d_s3);
	assign st5 = div_step2(rem_s4, low_s4[7:6], d_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1   <= alpha;
			sat_s1 <= color >= {1'b0, alpha};
			pm_s1  <= color[8] ? CHAN_MAX : color[7:0];
			rem_s1 <= num[15:8];
			low_s1 <= num[7:0];

			d_s2   <= d_s1;
			sat_s2 <= sat_s1;
			pm_s2  <= pm_s1;
			rem_s2 <= st2.rem;
			low_s2 <= {low_s1[5:0], 2'b00};
			q_s2   <= {6'd0, st2.q};

			d_s3   <= d_s2;
			sat_s3 <= sat_s2;
			pm_s3  <= pm_s2;
			rem_s3 <= st3.rem;
			low_s3 <= {low_s2[5:0], 2'b00};
			q_s3   <= {q_s2[5:0], st3.q};

			d_s4   <= d_s3;
			sat_s4 <= sat_s3;
			pm_s4  <= pm_s3;
			rem_s4 <= st4.rem;
			low_s4 <= {low_s3[5:0], 2'b00};
			q_s4   <= {q_s3[5:0], st4.q};

			d_s5   <= d_s4;
			sat_s5 <= sat_s4;
			pm_s5  <= pm_s4;
			q_s5   <= {q_s4[5:0], st5.q};
		end
	end

	assign res.valid = valid_s5;
	assign res.alpha = d_s5;
	assign res.level = premult ? pm_s5 : (sat_s5 ? CHAN_MAX : q_s5);

endmodule

FILE: hw/rtl/cta_checker.sv
// Port-level checks of the compositor, bound to its top level.
module cta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] argb_pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(argb_pixel))
		else $error("output word changed while stalled");

	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && argb_pixel[31:24] == 8'd0 |-> argb_pixel == 32'd0)
		else $error("transparent pixel carries colour");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_free_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked with free output");

endmodule

bind coverage_to_argb_compositor cta_checker u_cta_checker (.*);
